[design/rpf_pkg.sv]
// ----------------------------------------------------------------------------
// rpf_pkg: shared definitions for the RGB pixel fader
// Field widths, operation and register codes, and the command and status
// groups between the fader controller and its datapath.
// ----------------------------------------------------------------------------
package rpf_pkg;

  localparam int MAX_PIXELS_DEF = 64;
  localparam int FRAC_BITS_DEF  = 7;

  localparam int CHAN_W   = 8;
  localparam int CHAN_MAX = 255;
  localparam int OP_W     = 2;
  localparam int IDX_W    = 6;
  localparam int FADE_W   = 15;
  localparam int PC_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int NUM_CHAN = 3;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_STEP   = 2'd1,
    OP_REWIND = 2'd2
  } op_e;

  localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEPS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic div_start;  // capture a load transaction and start the divide
    logic run_start;  // rewind the pixel pointer for a step or rewind run
    logic rd_issue;   // read the next pixel row
    logic is_step;    // current run steps (else rewinds)
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ld_idx_ok;  // load index is below the pixel store depth
    logic cnt_zero;   // no pixels to emit
    logic rd_free;    // read stage can take a row this cycle
    logic rd_busy;    // read stage holds a row
    logic rd_at_end;  // pointer sits on the final pixel of the run
    logic div_done;   // quotients ready, rows written this cycle
  } sts_t;

endpackage

[design/rpf_ctrl.sv]
// ----------------------------------------------------------------------------
// rpf_ctrl: sequencing for the RGB pixel fader
// Accepts transactions, starts loads and emit runs, paces pixel reads.
// ----------------------------------------------------------------------------
module rpf_ctrl
  import rpf_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [OP_W-1:0] op_i,
  input  sts_t            sts_i,
  output cmd_t            cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RUN,
    ST_DRAIN
  } state_e;

  state_e state_q;
  logic   is_step_q;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o           = '0;
    cmd_o.is_step   = is_step_q;
    cmd_o.div_start = accept && (op_i == OP_LOAD) && sts_i.ld_idx_ok;
    cmd_o.run_start = accept && ((op_i == OP_STEP) || (op_i == OP_REWIND)) &&
                      !sts_i.cnt_zero;
    cmd_o.rd_issue  = (state_q == ST_RUN) && sts_i.rd_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      is_step_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.div_start) begin
            state_q <= ST_DIV;
          end else if (cmd_o.run_start) begin
            state_q   <= ST_RUN;
            is_step_q <= (op_i == OP_STEP);
          end
        end
        ST_DIV: begin
          if (sts_i.div_done) begin
            state_q <= ST_IDLE;
          end
        end
        ST_RUN: begin
          if (cmd_o.rd_issue && sts_i.rd_at_end) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // wait for the final row to be written back
          if (!sts_i.rd_busy) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[design/rpf_datapath.sv]
// ----------------------------------------------------------------------------
// rpf_datapath: storage and arithmetic for the RGB pixel fader
// Pixel row stores, three-lane restoring divider, step and saturate,
// read stage and output register.
// ----------------------------------------------------------------------------
module rpf_datapath
  import rpf_pkg::*;
#(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [FADE_W-1:0]    cfg_data_i,
  input  logic [IDX_W-1:0]     pixel_index_i,
  input  logic [CHAN_W-1:0]    start_red_i,
  input  logic [CHAN_W-1:0]    start_green_i,
  input  logic [CHAN_W-1:0]    start_blue_i,
  input  logic [CHAN_W-1:0]    end_red_i,
  input  logic [CHAN_W-1:0]    end_green_i,
  input  logic [CHAN_W-1:0]    end_blue_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [IDX_W-1:0]     out_index_o,
  output logic [CHAN_W-1:0]    red_o,
  output logic [CHAN_W-1:0]    green_o,
  output logic [CHAN_W-1:0]    blue_o,
  output logic                 last_o
);

  localparam int AW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int NW  = CHAN_W + FRAC_BITS;   // accumulator and numerator width
  localparam int IW  = NW + 1;               // signed increment width
  localparam int SW  = NW + 2;               // step sum width
  localparam int DCW = $clog2(NW);
  localparam int EMIT_MAX = (MAX_PIXELS < 64) ? MAX_PIXELS : 64;
  localparam logic signed [SW-1:0] TOP = SW'(CHAN_MAX * (2 ** FRAC_BITS));

  // configuration
  logic [FADE_W-1:0] fade_steps_q;
  logic [PC_W-1:0]   pixel_count_q;
  logic [PC_W-1:0]   emit_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_steps_q  <= FADE_W'(1);
      pixel_count_q <= PC_W'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FADE_STEPS:  fade_steps_q  <= cfg_data_i;
        CFG_PIXEL_COUNT: pixel_count_q <= cfg_data_i[PC_W-1:0];
        default: ;
      endcase
    end
  end

  assign emit_n = (pixel_count_q > PC_W'(EMIT_MAX)) ? PC_W'(EMIT_MAX) : pixel_count_q;

  // pixel stores, one row of three channels per pixel
  logic [NUM_CHAN-1:0][NW-1:0]     acc_mem   [MAX_PIXELS];
  logic [NUM_CHAN-1:0][IW-1:0]     inc_mem   [MAX_PIXELS];
  logic [NUM_CHAN-1:0][CHAN_W-1:0] start_mem [MAX_PIXELS];

  // load capture and divider lanes
  logic [CHAN_W-1:0] ld_start [NUM_CHAN];
  logic [CHAN_W-1:0] ld_end   [NUM_CHAN];
  logic [AW-1:0]     ld_addr_q;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] st_q;
  logic [NW-1:0]     num_q [NUM_CHAN];
  logic [NW-1:0]     quo_q [NUM_CHAN];
  logic [FADE_W-1:0] rem_q [NUM_CHAN];
  logic              neg_q [NUM_CHAN];
  logic [FADE_W-1:0] divisor_q;
  logic [DCW-1:0]    div_cnt_q;
  logic              div_run_q;
  logic              div_done_q;

  logic [CHAN_W:0]   diff   [NUM_CHAN];
  logic [CHAN_W-1:0] mag    [NUM_CHAN];
  logic [FADE_W:0]   rem_sh [NUM_CHAN];
  logic [FADE_W:0]   rem_sub[NUM_CHAN];
  logic              ge     [NUM_CHAN];
  logic [NUM_CHAN-1:0][NW-1:0] acc_init;
  logic [NUM_CHAN-1:0][IW-1:0] delta;

  assign ld_start[0] = start_red_i;
  assign ld_start[1] = start_green_i;
  assign ld_start[2] = start_blue_i;
  assign ld_end[0]   = end_red_i;
  assign ld_end[1]   = end_green_i;
  assign ld_end[2]   = end_blue_i;

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      diff[c]    = {1'b0, ld_end[c]} - {1'b0, ld_start[c]};
      mag[c]     = diff[c][CHAN_W] ? CHAN_W'(-diff[c]) : diff[c][CHAN_W-1:0];
      rem_sh[c]  = {rem_q[c], num_q[c][NW-1]};
      ge[c]      = rem_sh[c] >= {1'b0, divisor_q};
      rem_sub[c] = ge[c] ? (rem_sh[c] - {1'b0, divisor_q}) : rem_sh[c];
      acc_init[c] = {st_q[c], {FRAC_BITS{1'b0}}};
      delta[c]    = neg_q[c] ? IW'(-{1'b0, quo_q[c]}) : {1'b0, quo_q[c]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_run_q  <= 1'b0;
      div_done_q <= 1'b0;
      div_cnt_q  <= '0;
    end else begin
      div_done_q <= div_run_q && (div_cnt_q == '0);
      if (cmd_i.div_start) begin
        div_run_q <= 1'b1;
        div_cnt_q <= DCW'(NW - 1);
      end else if (div_run_q) begin
        if (div_cnt_q == '0) begin
          div_run_q <= 1'b0;
        end else begin
          div_cnt_q <= div_cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      ld_addr_q <= AW'({1'b0, pixel_index_i});
      divisor_q <= (fade_steps_q == '0) ? FADE_W'(1) : fade_steps_q;
      for (int c = 0; c < NUM_CHAN; c++) begin
        st_q[c]  <= ld_start[c];
        num_q[c] <= {mag[c], {FRAC_BITS{1'b0}}};
        neg_q[c] <= diff[c][CHAN_W];
        quo_q[c] <= '0;
        rem_q[c] <= '0;
      end
    end else if (div_run_q) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        rem_q[c] <= rem_sub[c][FADE_W-1:0];
        quo_q[c] <= {quo_q[c][NW-2:0], ge[c]};
        num_q[c] <= {num_q[c][NW-2:0], 1'b0};
      end
    end
  end

  // run: pointer, read stage, step or rewind, output register
  logic [AW-1:0] rd_ptr_q;
  logic          rd_vld_q;
  logic [AW-1:0] rd_idx_q;
  logic          rd_last_q;
  logic          adv;
  logic          at_end;
  logic [NUM_CHAN-1:0][NW-1:0]     acc_rd_q;
  logic [NUM_CHAN-1:0][IW-1:0]     inc_rd_q;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] st_rd_q;
  logic [NUM_CHAN-1:0][NW-1:0]     acc_new;
  logic signed [SW-1:0]            sum [NUM_CHAN];

  logic              out_valid_q;
  logic [IDX_W-1:0]  out_index_q;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] colour_q;
  logic              last_q;

  assign adv    = rd_vld_q && (!out_valid_q || out_ready_i);
  assign at_end = ({{(PC_W-AW){1'b0}}, rd_ptr_q} == (emit_n - 1'b1));

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      sum[c] = $signed({2'b00, acc_rd_q[c]}) + $signed({inc_rd_q[c][IW-1], inc_rd_q[c]});
      if (!cmd_i.is_step) begin
        acc_new[c] = {st_rd_q[c], {FRAC_BITS{1'b0}}};
      end else if (sum[c] < 0) begin
        acc_new[c] = '0;
      end else if (sum[c] > TOP) begin
        acc_new[c] = TOP[NW-1:0];
      end else begin
        acc_new[c] = sum[c][NW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      rd_ptr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.run_start) begin
        rd_ptr_q <= '0;
      end else if (cmd_i.rd_issue) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (cmd_i.rd_issue) begin
        rd_vld_q <= 1'b1;
      end else if (adv) begin
        rd_vld_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      acc_rd_q  <= acc_mem[rd_ptr_q];
      inc_rd_q  <= inc_mem[rd_ptr_q];
      st_rd_q   <= start_mem[rd_ptr_q];
      rd_idx_q  <= rd_ptr_q;
      rd_last_q <= at_end;
    end
    if (adv) begin
      out_index_q <= IDX_W'({{(PC_W-AW){1'b0}}, rd_idx_q});
      last_q      <= rd_last_q;
      for (int c = 0; c < NUM_CHAN; c++) begin
        colour_q[c] <= acc_new[c][NW-1:FRAC_BITS];
      end
    end
  end

  // store writes: load rows at divide completion, accumulator write-back
  always_ff @(posedge clk_i) begin
    if (div_done_q) begin
      acc_mem[ld_addr_q]   <= acc_init;
      inc_mem[ld_addr_q]   <= delta;
      start_mem[ld_addr_q] <= st_q;
    end else if (adv) begin
      acc_mem[rd_idx_q] <= acc_new;
    end
  end

  always_comb begin
    sts_o.ld_idx_ok = ({1'b0, pixel_index_i} < PC_W'(MAX_PIXELS));
    sts_o.cnt_zero  = (emit_n == '0);
    sts_o.rd_free   = !rd_vld_q || adv;
    sts_o.rd_busy   = rd_vld_q;
    sts_o.rd_at_end = at_end;
    sts_o.div_done  = div_done_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign red_o       = colour_q[0];
  assign green_o     = colour_q[1];
  assign blue_o      = colour_q[2];
  assign last_o      = last_q;

endmodule

[design/rgb_pixel_fader.sv]
// ----------------------------------------------------------------------------
// rgb_pixel_fader: per-pixel linear colour fader for an LED strip
// Loads start and target colours per pixel, then steps or rewinds every
// pixel in use and streams out its current colour.
// ----------------------------------------------------------------------------
// A load transaction (op 0) stores one pixel's start colour and works out a
// signed fixed-point increment per channel, ((end - start) << FRAC_BITS) /
// fade_steps truncated toward zero; it emits nothing and uses the three-lane
// restoring divider that retires one quotient bit per cycle. A step (op 1)
// adds each increment to its accumulator, saturates to 0 .. 255 << FRAC_BITS
// and emits every used pixel's integer colour, pixel 0 first, last set on
// the final one; a rewind (op 2) restores the start colours and emits them.
// A run covers n pixels (n = pixel_count, capped at MAX_PIXELS and 64); the
// pixel stores have one read port, so one row is read, updated and written
// back per cycle while the output is not stalled. Load indexes at or above
// MAX_PIXELS and op 3 are taken and dropped; a fade_steps of zero divides
// by one. The next transaction is taken while the final result still waits
// in the output register. Write configuration only while the block is idle.
// Pixels must be loaded before a run reads them.
// ----------------------------------------------------------------------------
module rgb_pixel_fader
  import rpf_pkg::*;
#(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [FADE_W-1:0]    cfg_data_i,
  // input transactions
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [IDX_W-1:0]     pixel_index_i,
  input  logic [CHAN_W-1:0]    start_red_i,
  input  logic [CHAN_W-1:0]    start_green_i,
  input  logic [CHAN_W-1:0]    start_blue_i,
  input  logic [CHAN_W-1:0]    end_red_i,
  input  logic [CHAN_W-1:0]    end_green_i,
  input  logic [CHAN_W-1:0]    end_blue_i,
  // result transactions
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [IDX_W-1:0]     out_index_o,
  output logic [CHAN_W-1:0]    red_o,
  output logic [CHAN_W-1:0]    green_o,
  output logic [CHAN_W-1:0]    blue_o,
  output logic                 last_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequence transactions: start the divide on a load, pace the reads of a run
  rpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the pixel stores, the divider and the read and output stages
  rpf_datapath #(
    .MAX_PIXELS (MAX_PIXELS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_index_i (pixel_index_i),
    .start_red_i   (start_red_i),
    .start_green_i (start_green_i),
    .start_blue_i  (start_blue_i),
    .end_red_i     (end_red_i),
    .end_green_i   (end_green_i),
    .end_blue_i    (end_blue_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_index_o   (out_index_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .last_o        (last_o)
  );

endmodule
